[sv/alignment_coverage_binner_assert.svh]
// Assertion macros shared by the binner checker.
`ifndef ALIGNMENT_COVERAGE_BINNER_ASSERT_SVH
`define ALIGNMENT_COVERAGE_BINNER_ASSERT_SVH
`define ACB_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define ACB_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

[sv/acb_pkg.sv]
// Shared types and constants of the alignment coverage binner.
package acb_pkg;
   localparam int MAX_BINS = 65536;
   localparam logic [2:0] CSR_BIN_SIZE = 3'd0;
   localparam logic [2:0] CSR_TARGET_BINS = 3'd1;
   localparam logic [2:0] CSR_READ_SHIFT = 3'd2;
   localparam logic [2:0] CSR_READ_MODE = 3'd3;
   localparam logic [2:0] CSR_MAPQ_MIN = 3'd4;
   localparam logic [2:0] CSR_MAPQ_MAX = 3'd5;
   localparam logic [2:0] CSR_ISIZE_MIN = 3'd6;
   localparam logic [2:0] CSR_ISIZE_MAX = 3'd7;
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic op;
      logic [11:0] flags;
      logic [7:0] mapq;
      logic signed [31:0] insert_size;
      logic [30:0] start_pos;
      logic [30:0] end_pos;
      logic [15:0] bin_index;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic [15:0] bin;
      logic [31:0] count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] bin_size;
      logic [16:0] target_bins;
      logic signed [15:0] read_shift;
      logic [2:0] read_mode;
      logic [7:0] mapq_min;
      logic [7:0] mapq_max;
      logic signed [31:0] isize_min;
      logic signed [31:0] isize_max;
   } cfg_type;

   // Work item handed from the front part to the back part.
   typedef struct packed {
      logic read_op;
      logic hit;
      logic [15:0] bin;
   } job_type;
endpackage

[sv/acb_ram.sv]
// Generic single-port RAM with registered read.
module acb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input logic clock,
   input logic we,
   input logic [$clog2(DEPTH)-1:0] addr,
   input logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

[sv/acb_front.sv]
// Front part: filters an alignment, forms its position and divides it into a bin.
module acb_front (
   input logic clock,
   input logic reset,
   input logic go,
   input acb_pkg::req_type req,
   input acb_pkg::cfg_type cfg,
   output logic done,
   output acb_pkg::job_type job
);
   import acb_pkg::*;
   typedef enum logic [2:0] {
      F_IDLE = 3'b001, F_DIV = 3'b010, F_DONE = 3'b100
   } fstate_type;
   fstate_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [33:0] rem_ff, rem_in, quo_ff, quo_in;
   logic ok_ff, ok_in, rd_ff, rd_in;
   logic [15:0] idx_ff, idx_in;

   logic rev, pass;
   logic [1:0] strand;
   logic signed [33:0] aisz, isz, base, twice, pos, sgn;
   logic [34:0] trial;

   always_comb begin
      rev = req.flags[4];
      strand = cfg.read_mode[2:1];
      isz = 34'(req.insert_size);
      aisz = isz < 0 ? -isz : isz;
      pass = 1'b1;
      if (strand == 2'd1 && rev) pass = 1'b0;
      if (strand[1] && !rev) pass = 1'b0;
      if (req.mapq < cfg.mapq_min || req.mapq > cfg.mapq_max) pass = 1'b0;
      if (cfg.isize_min != -32'sd1 && aisz < 34'(cfg.isize_min)) pass = 1'b0;
      if (cfg.isize_max != -32'sd1 && aisz > 34'(cfg.isize_max)) pass = 1'b0;
      base = rev ? $signed({3'b0, req.end_pos}) - 34'sd1 : $signed({3'b0, req.start_pos});
      sgn = isz > 0 ? 34'sd1 : (isz < 0 ? -34'sd1 : 34'sd0);
      twice = (base <<< 1) + isz - sgn;
      if (cfg.read_mode[0]) begin
         if (!req.flags[1] || req.flags[7]) pass = 1'b0;
         pos = (twice < 0) ? -((-twice) >>> 1) : (twice >>> 1);
      end else begin
         if (req.flags[2]) pass = 1'b0;
         pos = rev ? base - 34'(cfg.read_shift) : base + 34'(cfg.read_shift);
      end
      if (cfg.bin_size == 16'd0 || pos < 0) pass = 1'b0;
      trial = {rem_ff, quo_ff[33]} - {19'd0, cfg.bin_size};
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; rem_in = rem_ff; quo_in = quo_ff;
      ok_in = ok_ff; rd_in = rd_ff; idx_in = idx_ff;
      unique case (state_ff)
         F_IDLE: if (go) begin
            rd_in = req.op == OP_READ; idx_in = req.bin_index;
            ok_in = pass; rem_in = '0; quo_in = pos; cnt_in = 6'd34;
            state_in = (req.op == OP_READ || !pass) ? F_DONE : F_DIV;
         end
         F_DIV: begin
            if (!trial[34]) rem_in = trial[33:0];
            else rem_in = {rem_ff[32:0], quo_ff[33]};
            quo_in = {quo_ff[32:0], !trial[34]};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) state_in = F_DONE;
         end
         F_DONE: begin
            state_in = F_IDLE;
            if (!rd_ff && ok_ff) begin
               ok_in = quo_ff < 34'(cfg.target_bins) && quo_ff < 34'(MAX_BINS);
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
      cnt_ff <= cnt_in; rem_ff <= rem_in; quo_ff <= quo_in;
      ok_ff <= ok_in; rd_ff <= rd_in; idx_ff <= idx_in;
   end

   assign done = state_ff == F_DONE;
   always_comb begin
      job.read_op = rd_ff;
      job.hit = rd_ff ? (32'(idx_ff) < 32'(MAX_BINS))
         : (ok_ff && quo_ff < 34'(cfg.target_bins) && quo_ff < 34'(MAX_BINS));
      job.bin = rd_ff ? idx_ff : quo_ff[15:0];
   end
endmodule

[sv/acb_back.sv]
// Back part: clears the store after reset and updates, or reads and clears, one bin.
module acb_back (
   input logic clock,
   input logic reset,
   input logic job_valid,
   input acb_pkg::job_type job,
   output logic idle,
   output logic rsp_strobe,
   output acb_pkg::rsp_type rsp
);
   import acb_pkg::*;
   localparam int AW = $clog2(MAX_BINS);
   typedef enum logic [3:0] {
      B_CLR = 4'b0001, B_IDLE = 4'b0010, B_RD = 4'b0100, B_WR = 4'b1000
   } bstate_type;
   bstate_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   job_type job_ff, job_in;
   logic we;
   logic [AW-1:0] addr;
   logic [31:0] wdata, rdata, inc;
   logic strobe_ff, strobe_in;
   rsp_type rsp_ff, rsp_in;

   acb_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; job_in = job_ff;
      we = 1'b0; addr = job_ff.bin[AW-1:0]; wdata = '0;
      strobe_in = 1'b0; rsp_in = rsp_ff;
      inc = (rdata == 32'hFFFF_FFFF) ? rdata : rdata + 32'd1;
      unique case (state_ff)
         B_CLR: begin
            we = 1'b1; addr = clr_ff; clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_BINS - 1)) state_in = B_IDLE;
         end
         B_IDLE: if (job_valid) begin
            job_in = job;
            if (job.hit) begin
               addr = job.bin[AW-1:0]; state_in = B_RD;
            end else begin
               strobe_in = 1'b1;
               rsp_in = '{accepted: 1'b0, bin: job.read_op ? job.bin : 16'd0, count: 32'd0};
            end
         end
         B_RD: state_in = B_WR;
         B_WR: begin
            we = 1'b1; strobe_in = 1'b1; state_in = B_IDLE;
            wdata = job_ff.read_op ? 32'd0 : inc;
            rsp_in = '{accepted: !job_ff.read_op, bin: job_ff.bin,
                       count: job_ff.read_op ? rdata : inc};
         end
         default: state_in = B_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLR; clr_ff <= '0; strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; strobe_ff <= strobe_in;
      end
      job_ff <= job_in; rsp_ff <= rsp_in;
   end

   assign idle = state_ff == B_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp = rsp_ff;
endmodule

[sv/alignment_coverage_binner.sv]
// Top level of the alignment coverage binner.
// Path to rsp_strobe: an add that passes its filters runs the 34-step shift-subtract
// divider in the front part; a read request or a rejected add skips it. A read, or
// an add that lands in a bin, then takes the read-modify-write; an add whose bin is
// out of range is answered without it. One request is in flight at a time; the next
// is accepted only after rsp_strobe. After reset the bin store is cleared one entry
// a cycle, with busy high; configuration writes are taken throughout.
module alignment_coverage_binner (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input acb_pkg::req_type req_data,
   output logic rsp_strobe,
   output acb_pkg::rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [2:0] csr_index,
   input logic [31:0] csr_data
);
   import acb_pkg::*;
   cfg_type cfg_ff;
   logic inflight_ff, go, fdone, bidle, qv_ff;
   job_type fjob, q_ff;

   assign csr_ready = 1'b1;
   assign busy = inflight_ff || !bidle;
   assign go = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{bin_size: 16'd25, target_bins: 17'd0, read_shift: 16'sd0,
                     read_mode: 3'd0, mapq_min: 8'd0, mapq_max: 8'd255,
                     isize_min: -32'sd1, isize_max: -32'sd1};
         inflight_ff <= 1'b0; qv_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BIN_SIZE: cfg_ff.bin_size <= csr_data[15:0];
               CSR_TARGET_BINS: cfg_ff.target_bins <= csr_data[16:0];
               CSR_READ_SHIFT: cfg_ff.read_shift <= csr_data[15:0];
               CSR_READ_MODE: cfg_ff.read_mode <= csr_data[2:0];
               CSR_MAPQ_MIN: cfg_ff.mapq_min <= csr_data[7:0];
               CSR_MAPQ_MAX: cfg_ff.mapq_max <= csr_data[7:0];
               CSR_ISIZE_MIN: cfg_ff.isize_min <= csr_data;
               CSR_ISIZE_MAX: cfg_ff.isize_max <= csr_data;
               default: ;
            endcase
         end
         if (go) inflight_ff <= 1'b1;
         else if (rsp_strobe) inflight_ff <= 1'b0;
         if (fdone) qv_ff <= 1'b1;
         else if (bidle) qv_ff <= 1'b0;
      end
      if (fdone) q_ff <= fjob;
   end

   acb_front u_front (
      .clock(clock), .reset(reset), .go(go), .req(req_data), .cfg(cfg_ff),
      .done(fdone), .job(fjob)
   );

   acb_back u_back (
      .clock(clock), .reset(reset), .job_valid(qv_ff), .job(q_ff),
      .idle(bidle), .rsp_strobe(rsp_strobe), .rsp(rsp_data)
   );
endmodule

[sv/acb_checker.sv]
// Port-level checker for the alignment coverage binner, with its bind.
`include "alignment_coverage_binner_assert.svh"
module acb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input acb_pkg::rsp_type rsp_data
);
   `ACB_ASSERT_NXT(a_go_busy, clock, reset, start && !busy, busy)
   `ACB_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `ACB_ASSERT_NXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `ACB_ASSERT_IMP(a_hit_count, clock, reset, rsp_strobe && rsp_data.accepted, rsp_data.count != 32'd0)
endmodule

bind alignment_coverage_binner acb_checker u_acb_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
);
